>>> rtl/core/lps_pkg.sv
// shared types, constants and helpers for the scaled led pulse serializer
package lps_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int CNT_W         = $clog2(BITS_PER_BYTE);
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd4;

  localparam logic [CFG_W-1:0] RST_BRIGHTNESS = 8'd255;
  localparam logic [CFG_W-1:0] RST_ONE_HIGH   = 8'd19;
  localparam logic [CFG_W-1:0] RST_ONE_LOW    = 8'd11;
  localparam logic [CFG_W-1:0] RST_ZERO_HIGH  = 8'd10;
  localparam logic [CFG_W-1:0] RST_ZERO_LOW   = 8'd20;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_BYTE - 1);

  typedef struct packed {
    logic [BITS_PER_BYTE-1:0] pixel_byte;
    logic                     final_byte;
  } in_t;

  typedef struct packed {
    logic       bit_value;
    logic [7:0] high_cycles;
    logic [7:0] low_cycles;
    logic       last_of_byte;
    logic       end_of_strip;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] brightness;
    logic [CFG_W-1:0] one_high;
    logic [CFG_W-1:0] one_low;
    logic [CFG_W-1:0] zero_high;
    logic [CFG_W-1:0] zero_low;
  } cfg_t;

  // scaled byte handed from the input stage to the serializer
  typedef struct packed {
    logic                     valid;
    logic [BITS_PER_BYTE-1:0] data;
    logic                     final_byte;
  } load_t;

  // a pulse phase length is never below one
  function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
    return (v == '0) ? CFG_W'(1) : v;
  endfunction

endpackage

>>> rtl/core/led_pulse_serializer_scaled.sv
// top level of the scaled led pulse serializer
// Each accepted color byte is scaled by the brightness register as
// ((byte+1)*(brightness+1)-1)>>8 and sent out as eight pulse descriptor
// beats, most significant bit first, one beat per clock when out_ready
// stays high. The next byte waits in the input register and loads into
// the shifter in the cycle the previous byte's eighth beat is issued,
// leaving no gap. Into an idle block, an accepted byte passes through the
// input register, the shift register and the output register before its
// first beat appears. Timing registers written as zero read back as one;
// writes to indexes beyond four are ignored. Configure only while no byte
// is in flight.
module led_pulse_serializer_scaled
  import lps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t  cfg;
  load_t load;
  logic  load_take;

  lps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lps_scaler u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .brightness (cfg.brightness),
    .load_take  (load_take),
    .load       (load)
  );

  lps_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_take (load_take),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/lps_cfg_regs.sv
// configuration register file: brightness and pulse timing
module lps_cfg_regs
  import lps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.brightness <= RST_BRIGHTNESS;
      regs.one_high   <= RST_ONE_HIGH;
      regs.one_low    <= RST_ONE_LOW;
      regs.zero_high  <= RST_ZERO_HIGH;
      regs.zero_low   <= RST_ZERO_LOW;
    end else if (cfg_we) begin
      // timing values are clamped on write so readers never see zero
      unique case (cfg_index)
        REG_BRIGHTNESS: regs.brightness <= cfg_wdata;
        REG_ONE_HIGH:   regs.one_high   <= at_least_one(cfg_wdata);
        REG_ONE_LOW:    regs.one_low    <= at_least_one(cfg_wdata);
        REG_ZERO_HIGH:  regs.zero_high  <= at_least_one(cfg_wdata);
        REG_ZERO_LOW:   regs.zero_low   <= at_least_one(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> rtl/core/lps_scaler.sv
// input register and brightness scaling of the color byte
module lps_scaler
  import lps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  input  logic [CFG_W-1:0] brightness,
  input  logic             load_take,
  output load_t            load
);

  logic                     held;
  in_t                      held_data;
  logic [BITS_PER_BYTE:0]   op_a;
  logic [CFG_W:0]           op_b;
  logic [17:0]              prod;

  assign in_ready = !held || load_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

  // ((byte+1)*(brightness+1)-1)>>8, product before the minus one never below one
  always_comb begin
    op_a = {1'b0, held_data.pixel_byte} + 9'd1;
    op_b = {1'b0, brightness} + 9'd1;
    prod = 18'(op_a) * 18'(op_b) - 18'd1;
  end

  assign load.valid      = held;
  assign load.data       = prod[15:8];
  assign load.final_byte = held_data.final_byte;

endmodule

>>> rtl/core/lps_serializer.sv
// shift register that turns a scaled byte into eight pulse descriptors
module lps_serializer
  import lps_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  load_t load,
  output logic  load_take,
  input  cfg_t  cfg,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic                     busy;
  logic [BITS_PER_BYTE-1:0] shreg;
  logic [CNT_W-1:0]         cnt;
  logic                     fin;
  logic                     advance;
  logic                     emit;
  logic                     last;
  out_t                     beat;

  assign advance   = !out_valid || out_ready;
  assign emit      = busy && advance;
  assign last      = (cnt == LAST_BIT);
  // a new byte loads when idle, or on the cycle its predecessor's last beat leaves
  assign load_take = load.valid && (!busy || (emit && last));

  always_comb begin
    beat.bit_value    = shreg[BITS_PER_BYTE-1];
    beat.high_cycles  = shreg[BITS_PER_BYTE-1] ? cfg.one_high : cfg.zero_high;
    beat.low_cycles   = shreg[BITS_PER_BYTE-1] ? cfg.one_low  : cfg.zero_low;
    beat.last_of_byte = last;
    beat.end_of_strip = last && fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_take) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        busy <= !last;
        cnt  <= cnt + CNT_W'(1);
      end
      if (advance) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_take) begin
      shreg <= load.data;
      fin   <= load.final_byte;
    end else if (emit) begin
      shreg <= {shreg[BITS_PER_BYTE-2:0], 1'b0};
    end
    if (emit) begin
      out_data <= beat;
    end
  end

endmodule

>>> rtl/core/lps_checker.sv
// port level checks for the scaled led pulse serializer, bound to the top
module lps_checker
  import lps_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // strip end only on the closing beat of a byte
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_data.end_of_strip || out_data.last_of_byte)
    else $error("end_of_strip without last_of_byte");

  // pulse phase lengths are never zero
  a_nonzero_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.high_cycles != 8'd0 && out_data.low_cycles != 8'd0)
    else $error("zero length pulse phase");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an accepted beat that does not close its byte leaves the output valid
  a_byte_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_byte |=> out_valid)
    else $error("byte interrupted mid stream");

endmodule

bind led_pulse_serializer_scaled lps_checker u_chk (.*);

>>> dv/pulse_descriptor_checker.sv
// pulse descriptor checker: predicts the beats of each accepted byte and compares them
module pulse_descriptor_checker
  import lps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   beats_pending
);

  logic [CFG_W-1:0] gain;
  logic [CFG_W-1:0] one_hi;
  logic [CFG_W-1:0] one_lo;
  logic [CFG_W-1:0] zero_hi;
  logic [CFG_W-1:0] zero_lo;
  out_t             pending_pulses[$];

  function automatic logic [7:0] scale_color(input logic [7:0] raw, input logic [7:0] g);
    logic [16:0] prod;
    prod = ({9'd0, raw} + 17'd1) * ({9'd0, g} + 17'd1) - 17'd1;
    return prod[15:8];
  endfunction

  // a phase length of zero is stretched to one
  function automatic logic [7:0] no_shorter_than_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  task automatic queue_byte_pulses(input in_t beat);
    logic [7:0] shreg;
    out_t       p;
    shreg = scale_color(beat.pixel_byte, gain);
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      p.bit_value    = shreg[7];
      p.high_cycles  = no_shorter_than_one(shreg[7] ? one_hi : zero_hi);
      p.low_cycles   = no_shorter_than_one(shreg[7] ? one_lo : zero_lo);
      p.last_of_byte = (k == BITS_PER_BYTE - 1);
      p.end_of_strip = p.last_of_byte & beat.final_byte;
      pending_pulses.push_back(p);
      shreg = shreg << 1;
    end
  endtask

  task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got,
                             inout bit bad);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    bit   bad;
    if (rst) begin
      gain    = RST_BRIGHTNESS;
      one_hi  = RST_ONE_HIGH;
      one_lo  = RST_ONE_LOW;
      zero_hi = RST_ZERO_HIGH;
      zero_lo = RST_ZERO_LOW;
      pending_pulses.delete();
      errors  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BRIGHTNESS: gain    = cfg_wdata;
          REG_ONE_HIGH:   one_hi  = cfg_wdata;
          REG_ONE_LOW:    one_lo  = cfg_wdata;
          REG_ZERO_HIGH:  zero_hi = cfg_wdata;
          REG_ZERO_LOW:   zero_lo = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) queue_byte_pulses(in_data);
      if (out_valid && out_ready) begin
        if (pending_pulses.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          want = pending_pulses.pop_front();
          bad  = 1'b0;
          field_check("bit_value", 8'(want.bit_value), 8'(out_data.bit_value), bad);
          field_check("high_cycles", want.high_cycles, out_data.high_cycles, bad);
          field_check("low_cycles", want.low_cycles, out_data.low_cycles, bad);
          field_check("last_of_byte", 8'(want.last_of_byte), 8'(out_data.last_of_byte), bad);
          field_check("end_of_strip", 8'(want.end_of_strip), 8'(out_data.end_of_strip), bad);
          if (bad) errors++;
        end
      end
    end
    beats_pending = pending_pulses.size();
  end

endmodule

>>> dv/led_pulse_serializer_scaled_test.sv
// testbench top for the scaled led pulse serializer: stimulus, flow control and verdict
module led_pulse_serializer_scaled_test;
  import lps_pkg::*;

  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_ITEMS     = 50;
  localparam int RANDOM_PHASES   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] = '{REG_BRIGHTNESS, REG_ONE_HIGH,
                                                    REG_ONE_LOW, REG_ZERO_HIGH,
                                                    REG_ZERO_LOW};

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   beats_pending;
  bit                   idle_on      = 1'b1;
  bit                   hold_off_req = 1'b0;

  led_pulse_serializer_scaled dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pulse_descriptor_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .beats_pending (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] px, input logic fin);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.pixel_byte <= px;
    in_data.final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // all beats back, then wait out DRAIN_CYCLES before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] gain, input logic [7:0] oh,
                              input logic [7:0] ol, input logic [7:0] zh,
                              input logic [7:0] zl);
    logic [7:0] vals [5];
    vals = '{gain, oh, ol, zh, zl};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    // a write past the last register must change nothing
    cfg_index <= REG_ZERO_LOW + CFG_IDX_W'($urandom_range(1, 3));
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_duration();
    return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] corners [8];
    logic [7:0] gain;
    corners = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // corner bytes at the reset register values
    foreach (corners[i]) send_byte(corners[i], i[0]);
    wait_idle();
    // everything zero: no brightness, every duration stretched to one
    program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    wait_idle();
    program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_idle();
    program_regs(8'h80, 8'd1, 8'd255, 8'd255, 8'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h01, 1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
      gain = (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom);
      program_regs(gain, rand_duration(), rand_duration(), rand_duration(), rand_duration());
      // sender keeps pushing while the receiver holds off
      if (ph == 3) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_byte(rand_pixel(), $urandom_range(0, 7) == 0);
    end
    wait_idle();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lps_pkg.sv
rtl/core/lps_cfg_regs.sv
rtl/core/lps_scaler.sv
rtl/core/lps_serializer.sv
rtl/core/led_pulse_serializer_scaled.sv
rtl/core/lps_checker.sv
dv/pulse_descriptor_checker.sv
dv/led_pulse_serializer_scaled_test.sv
